// ===== src/spq_pkg.sv =====
// shared types and constants of the sorted priority queue
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ITEM_WIDTH  = 32;

    localparam int PRIO_W   = 32;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        ST_PUT_DONE = 2'd0,
        ST_GET_DONE = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        ACT_PUT = 1'b0,
        ACT_GET = 1'b1
    } action_t;

    // result word handed from the sequencer to the output register
    typedef struct packed {
        logic    valid;
        status_t status;
    } res_ctl_t;

endpackage

// ===== src/stable_sorted_priority_queue_core.sv =====
// top level of the stable sorted priority queue: handshakes and output register
//
// Bounded priority queue of QUEUE_DEPTH entries, each an item tag with a signed
// 32-bit priority, held in descending priority order in a ring buffer. A put
// (action 0) walks from the tail toward the head, one stored entry at a time:
// the single memory read port fetches the entry, then one priority
// compare decides whether to move it back a slot or drop the new word in
// behind it, so equal priorities leave in arrival order. A get (action 1)
// reads the head and advances the head pointer, no entries move. Every input
// word yields exactly one output word with status (0 put done, 1 get done,
// 2 queue empty, 3 queue full), the removed tag and priority on a good get
// (zero otherwise), and the entry count after the operation. The block takes
// one word at a time: in_stall is high from acceptance until the result is
// handed to the output register. The output register lets the next word be
// accepted while a result still waits on out_stall. Entries and the output
// payload hold no reset values; the count, pointers, state and the sequencer's
// result registers reset.
module stable_sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [HANDLE_W-1:0]        item_handle,
    input  logic signed [PRIO_W-1:0]   priority_req,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [HANDLE_W-1:0]        out_item,
    output logic signed [PRIO_W-1:0]   out_priority,
    output logic [COUNT_W-1:0]         entry_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    // widths for tag and count conversion between port and storage
    localparam int XW  = (ITEM_WIDTH > HANDLE_W) ? ITEM_WIDTH : HANDLE_W;
    localparam int XCW = (CW > COUNT_W) ? CW : COUNT_W;

    logic                     busy;
    logic                     in_fire;
    logic [XW-1:0]            in_item_x;
    logic [ITEM_WIDTH-1:0]    in_item;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [PRIO_W-1:0] wr_prio;
    logic [ITEM_WIDTH-1:0]    wr_item;
    logic [AW-1:0]            rd_addr;
    logic signed [PRIO_W-1:0] rd_prio;
    logic [ITEM_WIDTH-1:0]    rd_item;

    logic                     res_ready;
    res_ctl_t                 res_ctl;
    logic [ITEM_WIDTH-1:0]    res_item;
    logic signed [PRIO_W-1:0] res_prio;
    logic [CW-1:0]            res_count;
    logic [XW-1:0]            res_item_x;
    logic [XCW-1:0]           res_count_x;

    // output register: one result word waiting for the consumer
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [HANDLE_W-1:0]      out_item_reg;
    logic signed [PRIO_W-1:0] out_prio_reg;
    logic [COUNT_W-1:0]       out_count_reg;

    assign in_stall  = busy;
    assign in_fire   = in_valid && !busy;
    // only the low ITEM_WIDTH bits of the tag are kept
    assign in_item_x = XW'(item_handle);
    assign in_item   = in_item_x[ITEM_WIDTH-1:0];

    spq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_prio (wr_prio),
        .wr_item (wr_item),
        .rd_addr (rd_addr),
        .rd_prio (rd_prio),
        .rd_item (rd_item)
    );

    spq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_action (action_t'(action)),
        .in_item   (in_item),
        .in_prio   (priority_req),
        .busy      (busy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_prio   (wr_prio),
        .wr_item   (wr_item),
        .rd_addr   (rd_addr),
        .rd_prio   (rd_prio),
        .rd_item   (rd_item),
        .res_ready (res_ready),
        .res_ctl   (res_ctl),
        .res_item  (res_item),
        .res_prio  (res_prio),
        .res_count (res_count)
    );

    // the slot is free when empty or when its word leaves this cycle
    assign res_ready   = !out_valid_reg || !out_stall;
    assign res_item_x  = XW'(res_item);
    assign res_count_x = XCW'(res_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ctl.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload loads only when the slot is free, so a stalled word holds
    always_ff @(posedge clk)
    begin
        if (res_ctl.valid)
        begin
            out_status_reg <= res_ctl.status;
            out_item_reg   <= res_item_x[HANDLE_W-1:0];
            out_prio_reg   <= res_prio;
            out_count_reg  <= res_count_x[COUNT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_item     = out_item_reg;
    assign out_priority = out_prio_reg;
    assign entry_count  = out_count_reg;

endmodule

// ===== src/spq_store.sv =====
// entry storage: priority and item memories, one write and one registered read port
module spq_store
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH,
    localparam int AW = $clog2(QUEUE_DEPTH)
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [PRIO_W-1:0] wr_prio,
    input  logic [ITEM_WIDTH-1:0]    wr_item,
    input  logic [AW-1:0]            rd_addr,
    output logic signed [PRIO_W-1:0] rd_prio,
    output logic [ITEM_WIDTH-1:0]    rd_item
);

    logic [PRIO_W-1:0]     prio_mem [QUEUE_DEPTH];
    logic [ITEM_WIDTH-1:0] item_mem [QUEUE_DEPTH];

    logic [PRIO_W-1:0]     rd_prio_reg;
    logic [ITEM_WIDTH-1:0] rd_item_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[wr_addr] <= wr_prio;
            item_mem[wr_addr] <= wr_item;
        end
        rd_prio_reg <= prio_mem[rd_addr];
        rd_item_reg <= item_mem[rd_addr];
    end

    assign rd_prio = $signed(rd_prio_reg);
    assign rd_item = rd_item_reg;

endmodule

// ===== src/spq_seq.sv =====
// sequencer: ring pointers, insertion walk with the shared priority compare
module spq_seq
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_fire,
    input  action_t                  in_action,
    input  logic [ITEM_WIDTH-1:0]    in_item,
    input  logic signed [PRIO_W-1:0] in_prio,
    output logic                     busy,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic signed [PRIO_W-1:0] wr_prio,
    output logic [ITEM_WIDTH-1:0]    wr_item,
    output logic [AW-1:0]            rd_addr,
    input  logic signed [PRIO_W-1:0] rd_prio,
    input  logic [ITEM_WIDTH-1:0]    rd_item,
    input  logic                     res_ready,
    output res_ctl_t                 res_ctl,
    output logic [ITEM_WIDTH-1:0]    res_item,
    output logic signed [PRIO_W-1:0] res_prio,
    output logic [CW-1:0]            res_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT_RD,
        S_PUT_CMP,
        S_GET_OUT,
        S_RESULT
    } state_t;

    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_X   = (AW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    state_t                   state_reg;
    logic [AW-1:0]            head_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            pos_reg;
    logic signed [PRIO_W-1:0] new_prio_reg;
    logic [ITEM_WIDTH-1:0]    new_item_reg;
    status_t                  res_status_reg;
    logic [ITEM_WIDTH-1:0]    res_item_reg;
    logic signed [PRIO_W-1:0] res_prio_reg;

    logic [AW-1:0] pos_m1;
    logic [AW:0]   wr_sum;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] wr_phys;
    logic [AW-1:0] rd_phys;
    logic          keep_ahead;

    // logical slot to physical ring address, sum stays below twice the depth
    always_comb
    begin
        pos_m1  = (pos_reg == '0) ? '0 : pos_reg - AW'(1);
        wr_sum  = {1'b0, head_reg} + {1'b0, pos_reg};
        rd_sum  = {1'b0, head_reg} + {1'b0, pos_m1};
        wr_phys = (wr_sum >= DEPTH_X) ? AW'(wr_sum - DEPTH_X) : wr_sum[AW-1:0];
        rd_phys = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : rd_sum[AW-1:0];
    end

    // the shared compare: stored entry stays ahead on equal or higher priority
    assign keep_ahead = (rd_prio >= new_prio_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_phys;
        wr_prio = new_prio_reg;
        wr_item = new_item_reg;
        rd_addr = (state_reg == S_IDLE) ? head_reg : rd_phys;
        unique case (state_reg)
            S_PUT_RD:
            begin
                wr_en = (pos_reg == '0);
            end
            S_PUT_CMP:
            begin
                wr_en = 1'b1;
                if (!keep_ahead)
                begin
                    wr_prio = rd_prio;
                    wr_item = rd_item;
                end
            end
            S_IDLE, S_GET_OUT, S_RESULT:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            new_prio_reg   <= '0;
            new_item_reg   <= '0;
            res_status_reg <= ST_PUT_DONE;
            res_item_reg   <= '0;
            res_prio_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_item_reg <= '0;
                        res_prio_reg <= '0;
                        new_prio_reg <= in_prio;
                        new_item_reg <= in_item;
                        if (in_action == ACT_PUT)
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_RESULT;
                            end
                            else
                            begin
                                pos_reg   <= count_reg[AW-1:0];
                                state_reg <= S_PUT_RD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_reg <= ST_EMPTY;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_GET_OUT;
                        end
                    end
                end
                S_PUT_RD:
                begin
                    if (pos_reg == '0)
                    begin
                        count_reg      <= count_reg + CW'(1);
                        res_status_reg <= ST_PUT_DONE;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_PUT_CMP;
                    end
                end
                S_PUT_CMP:
                begin
                    priority if (keep_ahead)
                    begin
                        count_reg      <= count_reg + CW'(1);
                        res_status_reg <= ST_PUT_DONE;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        pos_reg   <= pos_m1;
                        state_reg <= S_PUT_RD;
                    end
                end
                S_GET_OUT:
                begin
                    res_item_reg   <= rd_item;
                    res_prio_reg   <= rd_prio;
                    head_reg       <= (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
                    count_reg      <= count_reg - CW'(1);
                    res_status_reg <= ST_GET_DONE;
                    state_reg      <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign res_ctl.valid     = (state_reg == S_RESULT) && res_ready;
    assign res_ctl.status    = res_status_reg;
    assign res_item          = res_item_reg;
    assign res_prio          = res_prio_reg;
    assign res_count         = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above queue depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_ctl.valid && res_ctl.status == ST_FULL |-> count_reg == DEPTH_C)
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_ctl.valid && res_ctl.status == ST_EMPTY |-> count_reg == '0)
        else $error("empty status with entries stored");

    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT_CMP && !keep_ahead |=> pos_reg == $past(pos_reg) - AW'(1))
        else $error("insertion walk skipped a slot");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_GET_OUT |=> $stable(head_reg))
        else $error("head moved outside a get");

endmodule
